// File: rtl/least_error_mirror_select_defines.svh
// Assertion macros for the least-error mirror select block.
// Used by the checker module; needs nothing else.
`ifndef LEAST_ERROR_MIRROR_SELECT_DEFINES_SVH
`define LEAST_ERROR_MIRROR_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LEMS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lems assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LEMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lems assertion failed");

`endif

// File: rtl/lems_pkg.sv
// Shared types, sizes and codes for the least-error mirror select block.
// No dependencies; every file but the defines header imports this package.
`default_nettype none

package lems_pkg;

    localparam int MAX_SOURCES = 8;
    localparam int IW          = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CW          = $clog2(MAX_SOURCES + 1);
    localparam int RND_W       = 16;
    localparam int ERR_W       = 8;

    localparam logic [ERR_W-1:0] ERR_SAT = '1;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_CHOOSE = 2'd2;
    localparam logic [1:0] CMD_GIVE   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SEQ   = 2'd3;

    typedef logic [CW-1:0] t_cnt;
    typedef logic [IW-1:0] t_idx;

    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic [6:0]       pref;
        logic [15:0]      loc;
        logic [7:0]       tag;
    } t_entry;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       mirror_tag;
        logic [6:0]       preference;
        logic [15:0]      location;
        logic [RND_W-1:0] random_value;
        logic             failed;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] chosen_tag;
        logic [3:0] tie_count;
        logic [3:0] entry_count;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/lems_if.sv
// Valid/ready channel interfaces for commands, results and configuration.
// Depends on lems_pkg for the payload types.
`default_nettype none

interface lems_in_if import lems_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lems_out_if import lems_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lems_cfg_if import lems_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/least_error_mirror_select.sv
// Top level of the least-error mirror select block: source table, sequencer
// and output register. Depends on lems_pkg, lems_if and lems_mod.
//
//  channel  | dir | carries                                   | ready
//  ---------+-----+-------------------------------------------+------------------
//  i_cfg    | in  | home_country                              | always high
//  i_in     | in  | cmd, tag, preference, location, rnd, fail | only when idle
//  o_res    | out | status, chosen_tag, tie_count, entry_count| from the sink
//
// Clear, add and give back go straight to S_DONE, which loads the result
// register once the output is free. Choose runs one scan of the table, the
// bit-serial remainder unit, a second scan, then compaction.
// Reset (synchronous, active low) empties the table, drops the held entry and
// clears home_country; there is no clearing pass.
// The next command is taken while a result still waits in the output register.
`default_nettype none

module least_error_mirror_select import lems_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lems_cfg_if.sink i_cfg,
    lems_in_if.sink  i_in,
    lems_out_if.source o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    t_cnt             r_count;
    logic             r_held_valid;
    logic [15:0]      r_home;
    t_entry           r_tbl [MAX_SOURCES];
    t_entry           r_held;
    t_idx             r_idx;
    t_idx             r_idx_pick;
    t_cnt             r_ties;
    t_cnt             r_seen;
    logic [ERR_W-1:0] r_min;
    logic [6:0]       r_maxp;
    logic             r_at_home;
    logic [RND_W-1:0] r_rnd;
    logic             r_mod_go;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_out_valid;

    logic   accept, full, last, home_set, here, match, out_free;
    logic   do_add, do_give, do_choose;
    logic   mod_done;
    t_cnt   mod_rem;
    t_entry rd;
    t_entry pick_entry;
    t_entry ret_entry;
    t_entry new_entry;
    t_out_item out_next;
    logic [1:0] quick_status;

    lems_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_go),
        .i_dividend (r_rnd),
        .i_divisor  (r_ties),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        accept   = i_in.valid && (r_state == S_IDLE);
        full     = r_count >= CW'(MAX_SOURCES);
        last     = (CW'(r_idx) + CW'(1)) == r_count;
        out_free = !r_out_valid || o_res.ready;
        rd       = r_tbl[r_idx];
        home_set = r_home != '0;
        here     = rd.loc == r_home;
        match    = (rd.err == r_min) && (rd.pref == r_maxp) && (!r_at_home || here);

        pick_entry     = rd;
        pick_entry.err = rd.err - r_min;

        out_next             = r_res;
        out_next.entry_count = 4'(r_count);

        new_entry.err  = '0;
        new_entry.pref = i_in.data.preference;
        new_entry.loc  = i_in.data.location;
        new_entry.tag  = i_in.data.mirror_tag;

        ret_entry = r_held;
        if (i_in.data.failed && (r_held.err != ERR_SAT)) begin
            ret_entry.err = r_held.err + ERR_W'(1);
        end

        do_add       = 1'b0;
        do_give      = 1'b0;
        do_choose    = 1'b0;
        quick_status = ST_OK;
        case (i_in.data.cmd)
            CMD_CLEAR: begin
                quick_status = ST_OK;
            end
            CMD_ADD: begin
                if (r_held_valid) begin
                    quick_status = ST_SEQ;
                end else if (full) begin
                    quick_status = ST_FULL;
                end else begin
                    do_add = accept;
                end
            end
            CMD_CHOOSE: begin
                if (r_held_valid) begin
                    quick_status = ST_SEQ;
                end else if (r_count == '0) begin
                    quick_status = ST_EMPTY;
                end else begin
                    do_choose = accept;
                end
            end
            CMD_GIVE: begin
                if (!r_held_valid) begin
                    quick_status = ST_SEQ;
                end else if (full) begin
                    quick_status = ST_FULL;
                end else begin
                    do_give = accept;
                end
            end
            default: begin
                quick_status = ST_SEQ;
            end
        endcase

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = do_choose ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (last) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_held_valid <= 1'b0;
            r_home       <= '0;
            r_idx        <= '0;
            r_mod_go     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mod_go <= (r_state == S_SCAN) && last;
            if (i_cfg.valid) begin
                r_home <= i_cfg.data;
            end
            if (accept) begin
                r_idx <= '0;
                if (i_in.data.cmd == CMD_CLEAR) begin
                    r_count      <= '0;
                    r_held_valid <= 1'b0;
                end
                if (do_add || do_give) begin
                    r_count <= r_count + CW'(1);
                end
                if (do_give) begin
                    r_held_valid <= 1'b0;
                end
            end
            if ((r_state == S_SCAN) || (r_state == S_PICK)) begin
                r_idx <= last ? '0 : (r_idx + IW'(1));
            end
            if (r_state == S_SHIFT) begin
                r_count      <= r_count - CW'(1);
                r_held_valid <= 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table, held entry, scan results and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rnd           <= i_in.data.random_value;
            r_res.status     <= quick_status;
            r_res.chosen_tag <= '0;
            r_res.tie_count  <= '0;
            r_res.entry_count <= '0;
            if (do_add) begin
                r_tbl[r_count[IW-1:0]] <= new_entry;
            end
            if (do_give) begin
                r_tbl[r_count[IW-1:0]] <= ret_entry;
            end
        end
        case (r_state)
            S_SCAN: begin
                if ((r_idx == '0) || (rd.err < r_min)) begin
                    r_min     <= rd.err;
                    r_maxp    <= rd.pref;
                    r_at_home <= home_set && here;
                    r_ties    <= CW'(1);
                end else if (rd.err == r_min) begin
                    if (home_set && here && !r_at_home) begin
                        r_at_home <= 1'b1;
                        r_maxp    <= rd.pref;
                        r_ties    <= CW'(1);
                    end else if (!home_set || (here == r_at_home)) begin
                        if (rd.pref > r_maxp) begin
                            r_maxp <= rd.pref;
                            r_ties <= CW'(1);
                        end else if (rd.pref == r_maxp) begin
                            r_ties <= r_ties + CW'(1);
                        end
                    end
                end
            end
            S_MOD: begin
                r_seen <= '0;
            end
            S_PICK: begin
                // rebase the error count; take the pick once its rank is reached
                r_tbl[r_idx].err <= pick_entry.err;
                if (match) begin
                    r_seen <= r_seen + CW'(1);
                    if (r_seen == mod_rem) begin
                        r_held     <= pick_entry;
                        r_idx_pick <= r_idx;
                    end
                end
            end
            S_SHIFT: begin
                // close the gap left by the pick
                for (int j = 0; j < MAX_SOURCES - 1; j++) begin
                    if (r_idx_pick <= IW'(j)) begin
                        r_tbl[j] <= r_tbl[j + 1];
                    end
                end
                r_res.status     <= ST_OK;
                r_res.chosen_tag <= r_held.tag;
                r_res.tie_count  <= 4'(r_ties);
            end
            default: begin
            end
        endcase
        if ((r_state == S_DONE) && out_free) begin
            r_out <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lems_mod.sv
// Bit-serial restoring remainder unit: random value modulo tie count.
// One quotient bit per cycle; depends on lems_pkg.
`default_nettype none

module lems_mod import lems_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  t_cnt             i_divisor,
    output logic             o_done,
    output t_cnt             o_rem
);

    localparam int SW = $clog2(RND_W);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_step;
    logic [RND_W-1:0] r_dvd;
    t_cnt             r_rem;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_dvd[RND_W-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = ge ? (trial - {1'b0, i_divisor}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out MSB first, keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= diff[CW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/lems_checker.sv
// Port-level checker for least_error_mirror_select, attached by bind.
// Depends on lems_pkg and least_error_mirror_select_defines.svh.
`default_nettype none
`include "least_error_mirror_select_defines.svh"

module lems_checker import lems_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status,
    input logic [7:0] i_out_tag,
    input logic [3:0] i_out_ties,
    input logic [3:0] i_out_count
);

    // a waiting result holds until taken
    `LEMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_tag) && $stable(i_out_ties) && $stable(i_out_count))
    // one command at a time: busy right after a transaction
    `LEMS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a refused command reports no pick
    `LEMS_ASSERT_IMPL(a_fail_no_pick, i_clk, i_rst_n, i_out_valid && (i_out_status != ST_OK), (i_out_tag == 8'd0) && (i_out_ties == 4'd0))
    // never more ties than the table can hold (MAX_SOURCES)
    `LEMS_ASSERT_IMPL(a_ties_bound, i_clk, i_rst_n, i_out_valid, 32'(i_out_ties) <= MAX_SOURCES)

endmodule

bind least_error_mirror_select lems_checker u_lems_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.data.status),
    .i_out_tag    (o_res.data.chosen_tag),
    .i_out_ties   (o_res.data.tie_count),
    .i_out_count  (o_res.data.entry_count)
);

`default_nettype wire
